/* hw/rtl/isr_pkg.sv */
// Shared types and constants for the in-order sequence reorder core.
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

   // Fixed field widths of the packet channels.
   localparam int SEQ_W = 32;
   localparam int DATA_W = 64;

   // Parameter defaults.
   localparam int WINDOW_DEF = 16;
   localparam int PAYLOAD_BITS_DEF = 64;

   // First sequence number expected after reset.
   localparam logic [SEQ_W-1:0] SEQ_START = 32'd1;

   // Result status codes.
   localparam logic STATUS_IN_ORDER = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // Operations of the shared sequence adder.
   typedef enum logic {
      ALU_SUB = 1'b0,
      ALU_INC = 1'b1
   } alu_op_type;

   // Classification of a sequence distance.
   typedef struct packed {
      logic is_zero;
      logic in_window;
      logic in_half;
   } seq_cls_type;

   // Control from the sequencer to the slot store.
   typedef struct packed {
      logic wr_en;
      logic adv;
   } slot_ctl_type;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CALC  = 5'b00010,
      S_FIRST = 5'b00100,
      S_OVF   = 5'b01000,
      S_DRAIN = 5'b10000
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/isr_alu.sv */
// Shared 32-bit sequence adder: distance to the expected number, or increment.
`timescale 1ns / 1ps
`default_nettype none

module isr_alu
   import isr_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  wire alu_op_type       op,
   input  wire logic [SEQ_W-1:0] seq,
   input  wire logic [SEQ_W-1:0] expected,
   output logic [SEQ_W-1:0]      sum,
   output seq_cls_type           cls
);

   logic [SEQ_W-1:0] opa;
   logic [SEQ_W-1:0] opb;

   // One adder with carry-in set: seq + ~expected + 1, or expected + 0 + 1.
   always_comb begin
      case (op)
         ALU_SUB: begin
            opa = seq;
            opb = ~expected;
         end
         ALU_INC: begin
            opa = expected;
            opb = '0;
         end
         default: begin
            opa = seq;
            opb = ~expected;
         end
      endcase
      sum = opa + opb + SEQ_W'(1);
   end

   assign cls.is_zero = (sum == '0);
   assign cls.in_window = (sum < SEQ_W'(WINDOW));
   assign cls.in_half = ~sum[SEQ_W-1];

endmodule

`default_nettype wire

/* hw/rtl/isr_slots.sv */
// Window slot store: valid bits, payload memory and the head pointer.
`timescale 1ns / 1ps
`default_nettype none

module isr_slots
   import isr_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
   localparam int IDX_W = $clog2(WINDOW)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire slot_ctl_type            ctl,
   input  wire logic [IDX_W-1:0]        wr_off,
   input  wire logic [PAYLOAD_BITS-1:0] wr_data,
   output logic                         next_valid,
   output logic [PAYLOAD_BITS-1:0]      rd_data
);

   logic [WINDOW-1:0]       valid_ff;
   logic [WINDOW-1:0]       valid_in;
   logic [IDX_W-1:0]        head_ff;
   logic [IDX_W-1:0]        head_in;
   logic [IDX_W-1:0]        head_plus1;
   logic [IDX_W:0]          wr_sum;
   logic [IDX_W-1:0]        wr_idx;
   logic                    wr_take;
   logic [PAYLOAD_BITS-1:0] mem_ff [WINDOW];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   // Offset is below WINDOW, so one conditional subtract wraps the index.
   always_comb begin
      wr_sum = {1'b0, head_ff} + {1'b0, wr_off};
      if (wr_sum >= (IDX_W+1)'(WINDOW)) begin
         wr_sum = wr_sum - (IDX_W+1)'(WINDOW);
      end
      wr_idx = wr_sum[IDX_W-1:0];
      if (head_ff == IDX_W'(WINDOW - 1)) begin
         head_plus1 = '0;
      end else begin
         head_plus1 = head_ff + IDX_W'(1);
      end
   end

   // A duplicate of a parked packet leaves the first copy in place.
   assign wr_take = ctl.wr_en & ~valid_ff[wr_idx];

   always_comb begin
      valid_in = valid_ff;
      head_in = head_ff;
      if (wr_take) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (ctl.adv) begin
         valid_in[head_ff] = 1'b0;
         head_in = head_plus1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         head_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_take) begin
         mem_ff[wr_idx] <= wr_data;
      end
   end

   // The slot after the head is fetched as the head steps onto it.
   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         rd_data_ff <= mem_ff[head_plus1];
      end
   end

   assign next_valid = valid_ff[head_plus1];
   assign rd_data = rd_data_ff;

   // A parked packet is always ahead of the head slot.
   a_no_write_at_head: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> (wr_idx != head_ff))
      else $error("slot write aimed at the head slot");

   // Stepping the head always frees the slot it leaves.
   a_adv_clears: assert property (@(posedge clock) disable iff (reset)
      ctl.adv |=> !valid_ff[$past(head_ff)])
      else $error("head slot still valid after advance");

endmodule

`default_nettype wire

/* hw/rtl/in_order_sequence_reorder_core.sv */
// Top level of the in-order sequence reorder core: sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_seq_num[31:0], req_payload[63:0]
// rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_out_seq[31:0],
//                                           rsp_out_payload[63:0], rsp_last
//
// A beat on req_ is classified by the shared 32-bit adder, which computes the
// distance to the expected number; a parked or dropped beat then frees the block.
// An overflow beat loads its single result once the output register is free.
// An in-order beat gives its own result after classification, and each buffered
// beat that continues the run follows the previous one while the output register
// is free; the same adder steps the expected number once per delivered result.
// Results leave through a single output register; while it is full and rsp_stall
// is high the sequencer waits on it and req_stall stays high.
// Synchronous reset sets the expected number to 1 and clears all slot valid
// bits at once; no clearing pass is needed.

module in_order_sequence_reorder_core
   import isr_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [SEQ_W-1:0]  req_seq_num,
   input  wire logic [DATA_W-1:0] req_payload,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_status,
   output logic [SEQ_W-1:0]       rsp_out_seq,
   output logic [DATA_W-1:0]      rsp_out_payload,
   output logic                   rsp_last
);

   localparam int IDX_W = $clog2(WINDOW);

   state_type               state_ff;
   state_type               state_in;
   logic [SEQ_W-1:0]        expected_ff;
   logic [SEQ_W-1:0]        expected_in;

   // Captured request beat.
   logic [SEQ_W-1:0]        seq_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;

   // Output register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_status_ff;
   logic                    rsp_status_in;
   logic [SEQ_W-1:0]        rsp_seq_ff;
   logic [SEQ_W-1:0]        rsp_seq_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff;
   logic [PAYLOAD_BITS-1:0] rsp_pay_in;
   logic                    rsp_last_ff;
   logic                    rsp_last_in;

   logic                    req_take;
   logic                    out_free;
   logic                    load_out;
   alu_op_type              alu_op;
   logic [SEQ_W-1:0]        alu_sum;
   seq_cls_type             cls;
   slot_ctl_type            slot_ctl;
   logic                    next_valid;
   logic [PAYLOAD_BITS-1:0] slot_data;

   isr_alu #(
      .WINDOW (WINDOW)
   ) u_alu (
      .op       (alu_op),
      .seq      (seq_ff),
      .expected (expected_ff),
      .sum      (alu_sum),
      .cls      (cls)
   );

   isr_slots #(
      .WINDOW       (WINDOW),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_slots (
      .clock      (clock),
      .reset      (reset),
      .ctl        (slot_ctl),
      .wr_off     (alu_sum[IDX_W-1:0]),
      .wr_data    (pay_ff),
      .next_valid (next_valid),
      .rd_data    (slot_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid & ~req_stall;

   // The output register can take a new result when empty or being drained.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // Sequencer. In the delivery states the adder steps the expected number,
   // and the run ends when the slot after the head holds nothing.
   always_comb begin
      state_in = state_ff;
      expected_in = expected_ff;
      alu_op = ALU_SUB;
      slot_ctl = '0;
      load_out = 1'b0;
      rsp_status_in = STATUS_IN_ORDER;
      rsp_seq_in = seq_ff;
      rsp_pay_in = pay_ff;
      rsp_last_in = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            alu_op = ALU_SUB;
            if (cls.is_zero) begin
               state_in = S_FIRST;
            end else if (cls.in_window) begin
               slot_ctl.wr_en = 1'b1;
               state_in = S_IDLE;
            end else if (cls.in_half) begin
               state_in = S_OVF;
            end else begin
               // Stale or duplicate of a delivered number: dropped.
               state_in = S_IDLE;
            end
         end
         S_FIRST: begin
            alu_op = ALU_INC;
            if (out_free) begin
               load_out = 1'b1;
               rsp_last_in = ~next_valid;
               slot_ctl.adv = 1'b1;
               expected_in = alu_sum;
               state_in = next_valid ? S_DRAIN : S_IDLE;
            end
         end
         S_OVF: begin
            if (out_free) begin
               load_out = 1'b1;
               rsp_status_in = STATUS_OVERFLOW;
               state_in = S_IDLE;
            end
         end
         S_DRAIN: begin
            alu_op = ALU_INC;
            rsp_seq_in = expected_ff;
            rsp_pay_in = slot_data;
            if (out_free) begin
               load_out = 1'b1;
               rsp_last_in = ~next_valid;
               slot_ctl.adv = 1'b1;
               expected_in = alu_sum;
               state_in = next_valid ? S_DRAIN : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         expected_ff <= SEQ_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         expected_ff <= expected_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         seq_ff <= req_seq_num;
         pay_ff <= req_payload[PAYLOAD_BITS-1:0];
      end
      if (load_out) begin
         rsp_status_ff <= rsp_status_in;
         rsp_seq_ff <= rsp_seq_in;
         rsp_pay_ff <= rsp_pay_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_seq = rsp_seq_ff;
   assign rsp_out_payload = DATA_W'(rsp_pay_ff);
   assign rsp_last = rsp_last_ff;

   // An accepted beat is classified in the very next cycle.
   a_take_to_calc: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_CALC))
      else $error("accepted beat not classified next cycle");

   // The expected number moves by exactly one per delivered result.
   a_expected_step: assert property (@(posedge clock) disable iff (reset)
      slot_ctl.adv |=> (expected_ff == $past(expected_ff) + SEQ_W'(1)))
      else $error("expected number did not step by one");

   // An overflow result is always the only, and thus last, result of its beat.
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_OVERFLOW)) |-> rsp_last_ff)
      else $error("overflow result without last");

endmodule

`default_nettype wire
